@@ sv/sgi_pkg.sv @@
package sgi_pkg;

  localparam int CW  = 32;
  localparam int PW  = CW + 1;
  localparam int DW  = 2 * PW + 1;
  localparam int CAW = 2 * CW + 1;
  localparam int NW  = CAW + PW + 1;
  localparam int QW  = CW + 1;
  localparam int FRONT_STAGES = 8;
  localparam int LAT = FRONT_STAGES + QW + 2;

  typedef struct packed {
    logic signed [CW-1:0] ax0;
    logic signed [CW-1:0] ay0;
    logic signed [CW-1:0] ax1;
    logic signed [CW-1:0] ay1;
    logic signed [CW-1:0] bx0;
    logic signed [CW-1:0] by0;
    logic signed [CW-1:0] bx1;
    logic signed [CW-1:0] by1;
  } crd_t;

  typedef struct packed {
    crd_t crd;
    logic negx;
    logic negy;
    logic miss;
  } side_t;

  typedef struct packed {
    logic [DW-1:0] d;
    logic [DW-1:0] rx;
    logic [DW-1:0] ry;
    logic [QW-1:0] nxl;
    logic [QW-1:0] nyl;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    side_t         side;
  } div_t;

endpackage

@@ sv/sgi_front.sv @@
module sgi_front import sgi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_v,
  input  crd_t  in_crd,
  output logic  out_v,
  output div_t  out_st
);

  logic [FRONT_STAGES-1:0] v_r;

  crd_t crd1_r, crd2_r, crd3_r, crd4_r, crd5_r, crd6_r, crd7_r;
  logic signed [PW-1:0] dax1_r, day1_r, dbx1_r, dby1_r;
  logic signed [PW-1:0] dax2_r, day2_r, dbx2_r, dby2_r;
  logic signed [PW-1:0] dax3_r, day3_r, dbx3_r, dby3_r;
  logic signed [2*PW-1:0] m_ad_r, m_bd_r;
  logic signed [2*CW-1:0] m_xa_r, m_ya_r, m_xb_r, m_yb_r;
  logic signed [DW-1:0] det3_r, det4_r, det5_r, det6_r;
  logic signed [CAW-1:0] ca3_r, cb3_r;
  logic signed [2*PW-1:0] pxa_lo_r, pxa_hi_r, pxb_lo_r, pxb_hi_r;
  logic signed [2*PW-1:0] pya_lo_r, pya_hi_r, pyb_lo_r, pyb_hi_r;
  logic signed [NW-1:0] tax_r, tbx_r, tay_r, tby_r;
  logic signed [NW-1:0] nx6_r, ny6_r;
  logic [NW-1:0] anx7_r, any7_r;
  logic [DW-1:0] ad7_r;
  logic negx7_r, negy7_r, zero7_r;
  div_t st8_r;

  logic signed [PW-1:0] ca_lo, ca_hi, cb_lo, cb_hi;
  logic [DW-1:0] hx, hy;
  logic ovfx, ovfy, miss;

  assign ca_lo = $signed({1'b0, ca3_r[CW-1:0]});
  assign ca_hi = $signed(ca3_r[CAW-1:CW]);
  assign cb_lo = $signed({1'b0, cb3_r[CW-1:0]});
  assign cb_hi = $signed(cb3_r[CAW-1:CW]);

  assign hx   = DW'(anx7_r >> QW);
  assign hy   = DW'(any7_r >> QW);
  assign ovfx = hx >= ad7_r;
  assign ovfy = hy >= ad7_r;
  assign miss = zero7_r || ovfx || ovfy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FRONT_STAGES-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    crd1_r <= in_crd;
    dax1_r <= PW'(in_crd.ax0) - PW'(in_crd.ax1);
    day1_r <= PW'(in_crd.ay0) - PW'(in_crd.ay1);
    dbx1_r <= PW'(in_crd.bx0) - PW'(in_crd.bx1);
    dby1_r <= PW'(in_crd.by0) - PW'(in_crd.by1);

    crd2_r <= crd1_r;
    dax2_r <= dax1_r;
    day2_r <= day1_r;
    dbx2_r <= dbx1_r;
    dby2_r <= dby1_r;
    m_ad_r <= dax1_r * dby1_r;
    m_bd_r <= day1_r * dbx1_r;
    m_xa_r <= crd1_r.ax0 * crd1_r.ay1;
    m_ya_r <= crd1_r.ay0 * crd1_r.ax1;
    m_xb_r <= crd1_r.bx0 * crd1_r.by1;
    m_yb_r <= crd1_r.by0 * crd1_r.bx1;

    crd3_r <= crd2_r;
    dax3_r <= dax2_r;
    day3_r <= day2_r;
    dbx3_r <= dbx2_r;
    dby3_r <= dby2_r;
    det3_r <= DW'(m_ad_r) - DW'(m_bd_r);
    ca3_r  <= CAW'(m_xa_r) - CAW'(m_ya_r);
    cb3_r  <= CAW'(m_xb_r) - CAW'(m_yb_r);

    crd4_r   <= crd3_r;
    det4_r   <= det3_r;
    pxa_lo_r <= ca_lo * dbx3_r;
    pxa_hi_r <= ca_hi * dbx3_r;
    pxb_lo_r <= dax3_r * cb_lo;
    pxb_hi_r <= dax3_r * cb_hi;
    pya_lo_r <= ca_lo * dby3_r;
    pya_hi_r <= ca_hi * dby3_r;
    pyb_lo_r <= day3_r * cb_lo;
    pyb_hi_r <= day3_r * cb_hi;

    crd5_r <= crd4_r;
    det5_r <= det4_r;
    tax_r  <= (NW'(pxa_hi_r) <<< CW) + NW'(pxa_lo_r);
    tbx_r  <= (NW'(pxb_hi_r) <<< CW) + NW'(pxb_lo_r);
    tay_r  <= (NW'(pya_hi_r) <<< CW) + NW'(pya_lo_r);
    tby_r  <= (NW'(pyb_hi_r) <<< CW) + NW'(pyb_lo_r);

    crd6_r <= crd5_r;
    det6_r <= det5_r;
    nx6_r  <= tax_r - tbx_r;
    ny6_r  <= tay_r - tby_r;

    crd7_r  <= crd6_r;
    anx7_r  <= nx6_r[NW-1] ? NW'(-nx6_r) : NW'(nx6_r);
    any7_r  <= ny6_r[NW-1] ? NW'(-ny6_r) : NW'(ny6_r);
    ad7_r   <= det6_r[DW-1] ? DW'(-det6_r) : DW'(det6_r);
    negx7_r <= nx6_r[NW-1] ^ det6_r[DW-1];
    negy7_r <= ny6_r[NW-1] ^ det6_r[DW-1];
    zero7_r <= det6_r == '0;

    st8_r.d         <= ad7_r;
    st8_r.rx        <= miss ? '0 : hx;
    st8_r.ry        <= miss ? '0 : hy;
    st8_r.nxl       <= miss ? '0 : anx7_r[QW-1:0];
    st8_r.nyl       <= miss ? '0 : any7_r[QW-1:0];
    st8_r.qx        <= '0;
    st8_r.qy        <= '0;
    st8_r.side.crd  <= crd7_r;
    st8_r.side.negx <= negx7_r;
    st8_r.side.negy <= negy7_r;
    st8_r.side.miss <= miss;
  end

  assign out_v  = v_r[FRONT_STAGES-1];
  assign out_st = st8_r;

endmodule

@@ sv/sgi_cell.sv @@
module sgi_cell import sgi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_v,
  input  div_t  in_st,
  output logic  out_v,
  output div_t  out_st
);

  logic       v_r;
  div_t       st_r;
  div_t       st_nxt;
  logic [DW:0] r2x, r2y;
  logic       gex, gey;

  // one quotient bit per lane
  always_comb begin
    r2x    = {in_st.rx, in_st.nxl[QW-1]};
    r2y    = {in_st.ry, in_st.nyl[QW-1]};
    gex    = r2x >= {1'b0, in_st.d};
    gey    = r2y >= {1'b0, in_st.d};
    st_nxt = in_st;
    st_nxt.rx  = gex ? DW'(r2x - {1'b0, in_st.d}) : DW'(r2x);
    st_nxt.ry  = gey ? DW'(r2y - {1'b0, in_st.d}) : DW'(r2y);
    st_nxt.nxl = {in_st.nxl[QW-2:0], 1'b0};
    st_nxt.nyl = {in_st.nyl[QW-2:0], 1'b0};
    st_nxt.qx  = {in_st.qx[QW-2:0], gex};
    st_nxt.qy  = {in_st.qy[QW-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_v  = v_r;
  assign out_st = st_r;

endmodule

@@ sv/segment_intersection_unit.sv @@
// a result strobes on out_valid once its item has passed the front end, the divider cells and the output registers
// throughput: one item per cycle, busy is never raised
// the rate is set by a fully pipelined front end and a chain of 33 divider
// cells, one quotient bit of both coordinates per cell
// reset (rst_n low, synchronous) clears all valid bits; items in flight are dropped and no result is invented
module segment_intersection_unit import sgi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_a_start_x,
  input  logic signed [CW-1:0] in_a_start_y,
  input  logic signed [CW-1:0] in_a_end_x,
  input  logic signed [CW-1:0] in_a_end_y,
  input  logic signed [CW-1:0] in_b_start_x,
  input  logic signed [CW-1:0] in_b_start_y,
  input  logic signed [CW-1:0] in_b_end_x,
  input  logic signed [CW-1:0] in_b_end_y,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic signed [CW-1:0] out_cross_x,
  output logic signed [CW-1:0] out_cross_y
);

  crd_t in_crd;
  logic v_w [QW+1];
  div_t st_w [QW+1];

  logic                 b1_v_r;
  side_t                b1_side_r;
  logic signed [QW:0]   qx1_r, qy1_r;
  logic                 hit_nxt;
  logic signed [QW:0]   cx0, cx1, cx2, cx3, cy0, cy1, cy2, cy3;
  logic                 spx_a, spx_b, spy_a, spy_b;
  logic                 hit_r, out_v_r;
  logic signed [CW-1:0] cross_x_r, cross_y_r;

  assign busy = 1'b0;

  assign in_crd.ax0 = in_a_start_x;
  assign in_crd.ay0 = in_a_start_y;
  assign in_crd.ax1 = in_a_end_x;
  assign in_crd.ay1 = in_a_end_y;
  assign in_crd.bx0 = in_b_start_x;
  assign in_crd.by0 = in_b_start_y;
  assign in_crd.bx1 = in_b_end_x;
  assign in_crd.by1 = in_b_end_y;

  sgi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (start && !busy),
    .in_crd (in_crd),
    .out_v  (v_w[0]),
    .out_st (st_w[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sgi_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_v   (v_w[i]),
      .in_st  (st_w[i]),
      .out_v  (v_w[i+1]),
      .out_st (st_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= v_w[QW];
      out_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b1_side_r <= st_w[QW].side;
    qx1_r <= st_w[QW].side.negx ? -$signed({1'b0, st_w[QW].qx}) : $signed({1'b0, st_w[QW].qx});
    qy1_r <= st_w[QW].side.negy ? -$signed({1'b0, st_w[QW].qy}) : $signed({1'b0, st_w[QW].qy});
  end

  // inclusive span tests against both segments
  always_comb begin
    cx0 = (QW+1)'(b1_side_r.crd.ax0);
    cx1 = (QW+1)'(b1_side_r.crd.ax1);
    cx2 = (QW+1)'(b1_side_r.crd.bx0);
    cx3 = (QW+1)'(b1_side_r.crd.bx1);
    cy0 = (QW+1)'(b1_side_r.crd.ay0);
    cy1 = (QW+1)'(b1_side_r.crd.ay1);
    cy2 = (QW+1)'(b1_side_r.crd.by0);
    cy3 = (QW+1)'(b1_side_r.crd.by1);
    spx_a = (qx1_r >= cx0 && qx1_r <= cx1) || (qx1_r >= cx1 && qx1_r <= cx0);
    spx_b = (qx1_r >= cx2 && qx1_r <= cx3) || (qx1_r >= cx3 && qx1_r <= cx2);
    spy_a = (qy1_r >= cy0 && qy1_r <= cy1) || (qy1_r >= cy1 && qy1_r <= cy0);
    spy_b = (qy1_r >= cy2 && qy1_r <= cy3) || (qy1_r >= cy3 && qy1_r <= cy2);
    hit_nxt = !b1_side_r.miss && spx_a && spx_b && spy_a && spy_b;
  end

  always_ff @(posedge clk) begin
    hit_r     <= hit_nxt;
    cross_x_r <= hit_nxt ? qx1_r[CW-1:0] : '0;
    cross_y_r <= hit_nxt ? qy1_r[CW-1:0] : '0;
  end

  assign out_valid   = out_v_r;
  assign out_hit     = hit_r;
  assign out_cross_x = cross_x_r;
  assign out_cross_y = cross_y_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid) else $error("item lost in pipeline");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("miss with nonzero point");

  a_miss_flag: assert property (@(posedge clk) disable iff (!rst_n)
    b1_v_r && b1_side_r.miss |=> !out_hit) else $error("hit despite miss flag");

endmodule

@@ test/segment_intersection_unit_tb.sv @@
`timescale 1ns / 1ps

module segment_intersection_unit_tb;
  import sgi_pkg::*;

  typedef struct {
    logic        hit;
    logic [31:0] cx;
    logic [31:0] cy;
  } cross_t;

  class cross_scoreboard;
    cross_t pending[$];
    int     errors;

    function automatic logic signed [255:0] sx(logic [31:0] v);
      return {{224{v[31]}}, v};
    endfunction

    function automatic logic in_range(logic signed [255:0] v, logic signed [255:0] p,
                                      logic signed [255:0] q);
      logic signed [255:0] lo, hi;
      lo = (p < q) ? p : q;
      hi = (p < q) ? q : p;
      return (v >= lo) && (v <= hi);
    endfunction

    function automatic void note_pair(logic [31:0] c[8]);
      logic signed [255:0] x1, y1, x2, y2, x3, y3, x4, y4;
      logic signed [255:0] dax, day, dbx, dby, det, ca, cb, px, py;
      cross_t e;
      x1 = sx(c[0]); y1 = sx(c[1]); x2 = sx(c[2]); y2 = sx(c[3]);
      x3 = sx(c[4]); y3 = sx(c[5]); x4 = sx(c[6]); y4 = sx(c[7]);
      dax = x1 - x2; day = y1 - y2; dbx = x3 - x4; dby = y3 - y4;
      det = dax * dby - day * dbx;
      e = '{1'b0, 32'd0, 32'd0};
      if (det != 0) begin
        ca = x1 * y2 - y1 * x2;
        cb = x3 * y4 - y3 * x4;
        px = (ca * dbx - dax * cb) / det;
        py = (ca * dby - day * cb) / det;
        if (in_range(px, x1, x2) && in_range(px, x3, x4) &&
            in_range(py, y1, y2) && in_range(py, y3, y4)) begin
          e = '{1'b1, px[31:0], py[31:0]};
        end
      end
      pending.push_back(e);
    endfunction

    function automatic void check_result(logic hit, logic [31:0] cx, logic [31:0] cy);
      cross_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result hit=%0b x=%h y=%h", $time, hit, cx, cy);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $display("%0t hit mismatch: expected %0b actual %0b", $time, e.hit, hit);
        errors++;
      end
      if (cx !== e.cx) begin
        $display("%0t cross_x mismatch: expected %h actual %h", $time, e.cx, cx);
        errors++;
      end
      if (cy !== e.cy) begin
        $display("%0t cross_y mismatch: expected %h actual %h", $time, e.cy, cy);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic signed [CW-1:0] c_in[8];
  logic out_valid, out_hit;
  logic signed [CW-1:0] out_cross_x, out_cross_y;
  cross_scoreboard sb;

  segment_intersection_unit u_top (
    .clk, .rst_n, .start, .busy,
    .in_a_start_x(c_in[0]), .in_a_start_y(c_in[1]),
    .in_a_end_x(c_in[2]), .in_a_end_y(c_in[3]),
    .in_b_start_x(c_in[4]), .in_b_start_y(c_in[5]),
    .in_b_end_x(c_in[6]), .in_b_end_y(c_in[7]),
    .out_valid, .out_hit, .out_cross_x, .out_cross_y
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_hit, out_cross_x, out_cross_y);
  end

  bit burst;

  task automatic send_pair(logic [31:0] c[8]);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    for (int i = 0; i < 8; i++) c_in[i] <= c[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pair(c);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 400)) - 200;
      2: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [31:0] c[8];
    int mode;
    sb = new();
    start = 0;
    rst_n = 0;
    burst = 0;
    for (int i = 0; i < 8; i++) c_in[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    c = '{32'h0, 32'h0, 32'h0002_0000, 32'h0002_0000,
          32'h0, 32'h0002_0000, 32'h0002_0000, 32'h0};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000,
          32'h0001_0000, 32'h0001_0000};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h5, 32'h5, 32'h5, 32'h5};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h1, 32'h1, 32'h3, 32'h0, 32'h4, 32'hffff_fffd};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h3, 32'h0, 32'h1, 32'hffff_ffff, 32'h2, 32'h2};
    send_pair(c);
    c = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    send_pair(c);
    c = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
    send_pair(c);
    c = '{32'h0, 32'h0, 32'h7, 32'h3, 32'h0, 32'h3, 32'h7, 32'h0};
    send_pair(c);
    c = '{32'hffff_fff9, 32'h0, 32'h0, 32'hffff_fffd, 32'hffff_fff9,
          32'hffff_fffd, 32'h0, 32'h0};
    send_pair(c);
    c = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h1, 32'h2, 32'h3, 32'h4};
    send_pair(c);
    c = '{32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h1, 32'h0, 32'h8000_0000,
          32'h1, 32'h7fff_ffff};
    send_pair(c);

    for (int n = 0; n < 550; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 8; i++) c[i] = rand_coord(mode);
      if ($urandom_range(0, 9) == 0) begin
        c[6] = c[4] + (c[2] - c[0]);
        c[7] = c[5] + (c[3] - c[1]);
      end
      send_pair(c);
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ segment_intersection_unit.f @@
sv/sgi_pkg.sv
sv/sgi_front.sv
sv/sgi_cell.sv
sv/segment_intersection_unit.sv
test/segment_intersection_unit_tb.sv
